// ===== hw/rtl/scpf_pkg.sv =====
package scpf_pkg;

    // Framing constants.
    localparam logic [7:0]  SYNC_BYTE_0 = 8'hAA;
    localparam logic [7:0]  SYNC_BYTE_1 = 8'h55;
    localparam logic [15:0] CRC_POLY_REFL = 16'hA001;
    localparam logic [15:0] CRC_INIT = 16'h0000;

    // Item kinds carried on the input tuser bit.
    localparam logic ACT_START   = 1'b0;
    localparam logic ACT_PAYLOAD = 1'b1;

    // Largest number of bytes one item can cause, and the counter width for it.
    localparam int BURST_MAX = 10;
    localparam int CNT_W     = $clog2(BURST_MAX + 1);

    localparam logic [CNT_W-1:0] CNT_HDR      = CNT_W'(8);
    localparam logic [CNT_W-1:0] CNT_HDR_CRC  = CNT_W'(10);
    localparam logic [CNT_W-1:0] CNT_DATA     = CNT_W'(1);
    localparam logic [CNT_W-1:0] CNT_DATA_CRC = CNT_W'(3);
    localparam logic [CNT_W-1:0] CNT_NONE     = CNT_W'(0);

    // All bytes caused by one item, lowest entry sent first.
    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [CNT_W-1:0]          count;
        logic                      frame_end;
    } t_burst;

    // One byte folded into a reflected CRC-16 (ARC polynomial).
    function automatic logic [15:0] crc16_fold(input logic [15:0] crc, input logic [7:0] din);
        logic [15:0] c;
        c = crc ^ {8'h00, din};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY_REFL;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// ===== hw/rtl/scpf_core.sv =====
module scpf_core
    import scpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_action,
    input  logic [7:0]  i_command,
    input  logic [7:0]  i_payload_len,
    input  logic [7:0]  i_data_byte,
    input  logic        i_load_ok,
    output logic        o_load,
    output t_burst      o_burst
);

    logic        r_in_valid;
    logic        r_action;
    logic [7:0]  r_command;
    logic [7:0]  r_len;
    logic [7:0]  r_data;

    logic [31:0] r_seq;
    logic [15:0] r_crc;
    logic [7:0]  r_remaining;
    logic        r_open;

    logic [31:0] n_seq;
    logic [15:0] n_crc;
    logic [7:0]  n_remaining;
    logic        n_open;
    logic        n_in_valid;

    logic        accept;
    logic [7:0]  len_byte;
    logic [7:0]  rem_dec;
    t_burst      burst;

    assign o_ready = !r_in_valid || i_load_ok;
    assign accept  = i_valid && o_ready;
    assign o_load  = r_in_valid && i_load_ok;
    assign n_in_valid = accept ? 1'b1 : (o_load ? 1'b0 : r_in_valid);

    assign len_byte = r_len + 8'd1;
    assign rem_dec  = r_remaining - 8'd1;

    always_comb begin
        n_seq       = r_seq;
        n_crc       = r_crc;
        n_remaining = r_remaining;
        n_open      = r_open;
        burst.bytes     = '0;
        burst.count     = CNT_NONE;
        burst.frame_end = 1'b0;
        if (r_action == ACT_START) begin
            n_seq       = r_seq + 32'd1;
            n_crc       = crc16_fold(CRC_INIT, r_command);
            n_remaining = r_len;
            n_open      = (r_len != 8'd0);
            burst.bytes[0] = SYNC_BYTE_0;
            burst.bytes[1] = SYNC_BYTE_1;
            burst.bytes[2] = r_seq[31:24];
            burst.bytes[3] = r_seq[23:16];
            burst.bytes[4] = r_seq[15:8];
            burst.bytes[5] = r_seq[7:0];
            burst.bytes[6] = len_byte;
            burst.bytes[7] = r_command;
            burst.bytes[8] = n_crc[7:0];
            burst.bytes[9] = n_crc[15:8];
            burst.count     = (r_len == 8'd0) ? CNT_HDR_CRC : CNT_HDR;
            burst.frame_end = (r_len == 8'd0);
        end else if (r_open) begin
            n_crc       = crc16_fold(r_crc, r_data);
            n_remaining = rem_dec;
            n_open      = (rem_dec != 8'd0);
            burst.bytes[0] = r_data;
            burst.bytes[1] = n_crc[7:0];
            burst.bytes[2] = n_crc[15:8];
            burst.count     = (rem_dec == 8'd0) ? CNT_DATA_CRC : CNT_DATA;
            burst.frame_end = (rem_dec == 8'd0);
        end
    end

    assign o_burst = burst;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_seq       <= '0;
            r_crc       <= '0;
            r_remaining <= '0;
            r_open      <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
            if (o_load) begin
                r_seq       <= n_seq;
                r_crc       <= n_crc;
                r_remaining <= n_remaining;
                r_open      <= n_open;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action  <= i_action;
            r_command <= i_command;
            r_len     <= i_payload_len;
            r_data    <= i_data_byte;
        end
    end

`ifndef NO_ASSERTIONS
    // A frame is open exactly while payload bytes are still owed.
    a_open_matches_remaining: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_open == (r_remaining != 8'd0))
        else $error("frame open flag disagrees with remaining count");

    // Every start item advances the sequence number by one.
    a_seq_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_load && r_action == ACT_START) |=> (r_seq == $past(r_seq) + 32'd1))
        else $error("sequence number did not advance on start");
`endif

endmodule

// ===== hw/rtl/scpf_burst.sv =====
module scpf_burst
    import scpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,
    input  t_burst      i_burst,
    output logic        o_load_ok,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_byte,
    output logic        o_last,
    output logic        o_frame_last
);

    logic [BURST_MAX-1:0][7:0] r_bytes;
    logic [CNT_W-1:0]          r_cnt;
    logic                      r_frame_end;

    logic take;

    assign o_valid      = (r_cnt != CNT_NONE);
    assign take         = o_valid && i_ready;
    assign o_load_ok    = (r_cnt == CNT_NONE) || ((r_cnt == CNT_DATA) && i_ready);
    assign o_byte       = r_bytes[0];
    assign o_last       = (r_cnt == CNT_DATA);
    assign o_frame_last = r_frame_end && (r_cnt == CNT_DATA);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= CNT_NONE;
        end else if (i_load) begin
            r_cnt <= i_burst.count;
        end else if (take) begin
            r_cnt <= r_cnt - CNT_DATA;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_bytes     <= i_burst.bytes;
            r_frame_end <= i_burst.frame_end;
        end else if (take) begin
            r_bytes <= r_bytes >> 8;
        end
    end

`ifndef NO_ASSERTIONS
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(BURST_MAX))
        else $error("burst count beyond its maximum");

    // A new burst is only loaded once the current one has gone or is leaving.
    a_load_safe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (r_cnt == CNT_NONE || (r_cnt == CNT_DATA && i_ready)))
        else $error("burst overwritten before it was sent");
`endif

endmodule

// ===== hw/rtl/seq_crc16_packet_framer.sv =====
// Packet framer with sequence numbers and a CRC-16/ARC trailer. Each input
// item is either a start (tuser low) carrying a command and a payload length,
// or a payload byte (tuser high). A start sends the eight header bytes 0xAA,
// 0x55, the 32-bit sequence number high byte first, length plus one and the
// command, then bumps the sequence number; a zero length closes the frame at
// once with the two CRC bytes, low byte first. Payload bytes of an open frame
// pass straight through, and the last counted one is followed by the CRC.
// Payload bytes with no frame open are dropped, and a start abandons any open
// frame. The output sends one byte per cycle while m_axis_tready is high. An
// item causes one byte for a payload byte, three for the last payload byte,
// eight for a start and ten for a start with zero length. A dropped payload
// byte causes no bytes but still passes through the pipeline. An accepted
// item sits in the input register and moves to the output register in the
// cycle the last byte of the previous item leaves, and the input takes a new
// item in that same cycle. With an idle output an item's first byte is offered
// once it has passed the input register and then the output register; payload
// items other than a frame's last flow at one item per cycle while tready is high.
module seq_crc16_packet_framer
    import scpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // command [7:0], payload_len [15:8], data_byte [23:16]
    input  logic        s_axis_tuser,  // action: 0 start, 1 payload byte
    // Framed byte stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte [7:0]
    output logic        m_axis_tlast,  // last byte caused by one input item
    output logic        m_axis_tuser   // frame_last: high CRC byte of the frame
);

    logic   load_ok;
    logic   load;
    t_burst burst;

    // Input register, framing state and the byte set for the held item.
    scpf_core u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_action      (s_axis_tuser),
        .i_command     (s_axis_tdata[7:0]),
        .i_payload_len (s_axis_tdata[15:8]),
        .i_data_byte   (s_axis_tdata[23:16]),
        .i_load_ok     (load_ok),
        .o_load        (load),
        .o_burst       (burst)
    );

    // Result register that shifts the item's bytes out one per cycle while m_axis_tready is high.
    scpf_burst u_burst (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_load       (load),
        .i_burst      (burst),
        .o_load_ok    (load_ok),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_byte       (m_axis_tdata),
        .o_last       (m_axis_tlast),
        .o_frame_last (m_axis_tuser)
    );

endmodule

// ===== tb/sv/tb_seq_crc16_packet_framer.sv =====
module tb_seq_crc16_packet_framer;
    import scpf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the whole run. The slowest correct run is well under a
    // tenth of this: every input item causes at most ten bytes, and the output
    // stall pattern never holds tready low for a whole pattern period.
    localparam int CYCLE_LIMIT = 1_000_000;
    // Target number of input items that cause bytes, for the random part.
    localparam int RANDOM_ITEMS = 300;
    // Cycles allowed for stray bytes after the last expected one has arrived.
    localparam int DRAIN_CYCLES = 24;
    // Mismatch lines beyond this count are counted but not printed.
    localparam int PRINT_CAP = 100;

    // One byte of the framed stream as the block should send it.
    typedef struct packed {
        logic [7:0] value;
        logic       item_end;
        logic       frame_end;
    } t_framed_byte;

    // Keeps its own copy of the framer state, works out the bytes that every
    // accepted item causes, and compares the bytes that come out against them
    // in order.
    class framer_scoreboard;
        logic [31:0]  seq_num;
        logic [15:0]  crc_acc;
        logic [7:0]   bytes_left;
        logic         frame_is_open;
        t_framed_byte expected_bytes[$];
        int           mismatches;

        function new();
            seq_num       = '0;
            crc_acc       = CRC_INIT;
            bytes_left    = '0;
            frame_is_open = 1'b0;
            mismatches    = 0;
        endfunction

        // Bit-serial form of the reflected CRC-16: each data bit, LSB first,
        // is compared with the register LSB and the polynomial is folded in
        // when they differ.
        function logic [15:0] fold_crc_byte(logic [15:0] crc, logic [7:0] data);
            logic [15:0] r;
            logic        fb;
            r = crc;
            for (int b = 0; b < 8; b++) begin
                fb = r[0] ^ data[b];
                r  = r >> 1;
                if (fb) begin
                    r = r ^ CRC_POLY_REFL;
                end
            end
            return r;
        endfunction

        function void push_byte(logic [7:0] value, logic frame_end);
            t_framed_byte e;
            e.value     = value;
            e.item_end  = 1'b0;
            e.frame_end = frame_end;
            expected_bytes.push_back(e);
        endfunction

        // The CRC goes out low byte first and closes the frame.
        function void push_crc_trailer();
            push_byte(crc_acc[7:0], 1'b0);
            push_byte(crc_acc[15:8], 1'b1);
            frame_is_open = 1'b0;
            bytes_left    = '0;
        endfunction

        function void note_item(logic act, logic [7:0] cmd, logic [7:0] len, logic [7:0] data);
            int first;
            first = expected_bytes.size();
            if (act == ACT_START) begin
                push_byte(SYNC_BYTE_0, 1'b0);
                push_byte(SYNC_BYTE_1, 1'b0);
                push_byte(seq_num[31:24], 1'b0);
                push_byte(seq_num[23:16], 1'b0);
                push_byte(seq_num[15:8], 1'b0);
                push_byte(seq_num[7:0], 1'b0);
                push_byte(len + 8'd1, 1'b0);
                push_byte(cmd, 1'b0);
                seq_num       = seq_num + 32'd1;
                crc_acc       = fold_crc_byte(CRC_INIT, cmd);
                bytes_left    = len;
                frame_is_open = 1'b1;
                if (len == 8'd0) begin
                    push_crc_trailer();
                end
            end else if (frame_is_open) begin
                push_byte(data, 1'b0);
                crc_acc    = fold_crc_byte(crc_acc, data);
                bytes_left = bytes_left - 8'd1;
                if (bytes_left == 8'd0) begin
                    push_crc_trailer();
                end
            end
            if (expected_bytes.size() > first) begin
                expected_bytes[expected_bytes.size() - 1].item_end = 1'b1;
            end
        endfunction

        task report(string msg);
            if (mismatches < PRINT_CAP) begin
                $display("%0t ERROR: %s", $realtime, msg);
            end
            mismatches++;
        endtask

        task check_byte(logic [7:0] value, logic item_end, logic frame_end);
            t_framed_byte e;
            if (expected_bytes.size() == 0) begin
                report($sformatf("unexpected byte %02h last=%0b frame_last=%0b",
                                 value, item_end, frame_end));
            end else begin
                e = expected_bytes.pop_front();
                if (value !== e.value || item_end !== e.item_end
                        || frame_end !== e.frame_end) begin
                    report($sformatf("byte %02h last=%0b frame_last=%0b, want %02h %0b %0b",
                                     value, item_end, frame_end,
                                     e.value, e.item_end, e.frame_end));
                end
            end
        endtask
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // command [7:0], payload_len [15:8], data_byte [23:16]
    logic        s_axis_tuser = ACT_START;  // action: 0 start, 1 payload byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;  // out_byte [7:0]
    logic        m_axis_tlast;  // last byte caused by one input item
    logic        m_axis_tuser;  // frame_last: high CRC byte of the frame

    framer_scoreboard sb = new();

    int          cycle_count = 0;
    int          burst_left = 0;
    int          rx_left = 0;
    logic [3:0]  rx_phase = '0;
    logic [15:0] rx_pattern = '1;

    seq_crc16_packet_framer dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Both handshakes are observed at the rising edge in one process, so an
    // input item is always noted before any byte it causes is checked, even
    // if the block were to answer within the same cycle.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                sb.note_item(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8],
                             s_axis_tdata[23:16]);
            end
            if (m_axis_tvalid && m_axis_tready) begin
                sb.check_byte(m_axis_tdata, m_axis_tlast, m_axis_tuser);
            end
        end
    end

    // Runaway guard.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    // Output side back-pressure. Every so often a new 16-bit ready pattern is
    // picked: always ready, random, sparse, or mostly ready. Bit zero is forced
    // high so a stall never lasts a full pattern period.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            case ($urandom_range(0, 3))
                0: rx_pattern = 16'hFFFF;
                1: rx_pattern = 16'($urandom) | 16'h0001;
                2: rx_pattern = 16'($urandom & $urandom) | 16'h0001;
                default: rx_pattern = 16'($urandom | $urandom) | 16'h0001;
            endcase
            rx_left = $urandom_range(16, 96);
        end
        m_axis_tready = rx_pattern[rx_phase];
        rx_phase      = rx_phase + 4'd1;
        rx_left--;
    end

    // Drives one item and returns at the rising edge where it is taken. Items
    // go out in bursts of random length; between bursts tvalid drops for a
    // random number of cycles, and a quarter of the bursts follow with no gap
    // at all. Fields that the item kind does not use carry random values.
    task automatic send_item(input logic act, input logic [7:0] cmd, input logic [7:0] len,
                             input logic [7:0] data);
        int idle;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (idle) begin
                @(negedge i_clk);
                s_axis_tvalid = 1'b0;
            end
        end
        burst_left--;
        @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = act;
        s_axis_tdata  = {data, len, cmd};
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
    endtask

    task automatic send_start(input logic [7:0] cmd, input logic [7:0] len);
        send_item(ACT_START, cmd, len, 8'($urandom));
    endtask

    task automatic send_payload(input logic [7:0] data);
        send_item(ACT_PAYLOAD, 8'($urandom), 8'($urandom), data);
    endtask

    initial begin
        int          counted;
        int          pick;
        int          n_payload;
        logic        gen_open;
        logic [7:0]  len;

        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part.
        // A payload byte straight after reset has no frame to join and is dropped.
        send_payload(8'h5A);
        // Zero length: header and CRC together, ten bytes from one item.
        send_start(8'h00, 8'd0);
        // Single payload byte, so that byte is also the last one.
        send_start(8'hFF, 8'd1);
        send_payload(8'hFF);
        send_start(8'hA5, 8'd2);
        send_payload(8'h00);
        send_payload(8'h80);
        // The frame is closed again, so this byte is dropped too.
        send_payload(8'h11);
        // A length of 255 gives a length byte of zero; the frame is then
        // abandoned by the next start.
        send_start(8'h3C, 8'd255);
        send_payload(8'h01);
        send_payload(8'h02);
        // Longest regular length, also abandoned after one byte.
        send_start(8'h01, 8'd246);
        send_payload(8'h55);
        send_start(8'h42, 8'd4);
        send_payload(8'hFE);
        // Start on an open frame: the old frame ends without a CRC.
        send_start(8'h7E, 8'd0);
        send_start(8'h96, 8'd3);
        send_payload(8'h69);
        send_payload(8'hC3);
        send_payload(8'h3C);

        // Random part. Mostly complete frames with random content and a
        // length that is usually short and only now and then near the
        // maximum; the rest are frames cut short by the next start and stray
        // payload bytes between frames.
        counted  = 0;
        gen_open = 1'b0;
        while (counted < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 8 && !gen_open) begin
                repeat ($urandom_range(1, 3)) begin
                    send_payload(8'($urandom));
                end
            end else begin
                if (pick < 20) begin
                    len       = 8'($urandom_range(1, 255));
                    n_payload = $urandom_range(0, (len > 8) ? 7 : len - 1);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 3) begin
                        len = 8'($urandom_range(150, 246));
                    end else if (pick < 15) begin
                        len = 8'($urandom_range(13, 60));
                    end else begin
                        len = 8'($urandom_range(0, 12));
                    end
                    n_payload = len;
                end
                send_start(8'($urandom), len);
                counted++;
                repeat (n_payload) begin
                    send_payload(8'($urandom));
                    counted++;
                end
                gen_open = (n_payload != len);
            end
        end

        @(negedge i_clk);
        s_axis_tvalid = 1'b0;

        // Let every expected byte arrive, then watch a while longer for extras.
        while (sb.expected_bytes.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.expected_bytes.size() != 0) begin
            sb.report($sformatf("%0d expected bytes never arrived", sb.expected_bytes.size()));
        end
        if (sb.mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
